// ===== hdl/assert_macros.svh =====
// Assertion shorthands shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while the synchronous reset is high
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, for blocks that use the usual clk and rst names
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLKD(label, clk, rst, prop, msg)

`endif

// ===== hdl/cpqc_pkg.sv =====
// Shared types, codes, constants and the step table of the cascaded PD controller
package cpqc_pkg;

  // Default widths and fixed field widths
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int FIELD_W        = 16;
  localparam int GAIN_W         = 16;

  // 1/9.8 as unsigned Q0.16
  localparam int INV_G_Q16 = 6687;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [GAIN_W-1:0]  gain_t;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_GAINS_X     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_Y     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_Z     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_ROLL  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_PITCH = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_YAW   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS_TARGET  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING     = 4'd7;

  // Axis codes; also the gain index and the result slot of each PD stage
  localparam int NUM_AX = 6;
  localparam int AX_W   = 3;
  localparam logic [AX_W-1:0] AX_X     = 3'd0;
  localparam logic [AX_W-1:0] AX_Y     = 3'd1;
  localparam logic [AX_W-1:0] AX_Z     = 3'd2;
  localparam logic [AX_W-1:0] AX_ROLL  = 3'd3;
  localparam logic [AX_W-1:0] AX_PITCH = 3'd4;
  localparam logic [AX_W-1:0] AX_YAW   = 3'd5;
  // Extra rounding destinations beyond the six result slots
  localparam logic [AX_W-1:0] DST_ROLL_REF  = 3'd6;
  localparam logic [AX_W-1:0] DST_PITCH_REF = 3'd7;

  // Multiplier operand selection
  localparam int MUL_W = 3;
  localparam logic [MUL_W-1:0] MUL_NONE    = 3'd0;
  localparam logic [MUL_W-1:0] MUL_HYK     = 3'd1;
  localparam logic [MUL_W-1:0] MUL_KP_ERR  = 3'd2;
  localparam logic [MUL_W-1:0] MUL_KD_DERR = 3'd3;
  localparam logic [MUL_W-1:0] MUL_DDX_HYK = 3'd4;
  localparam logic [MUL_W-1:0] MUL_DDY_KF  = 3'd5;
  localparam logic [MUL_W-1:0] MUL_DDX_KF  = 3'd6;
  localparam logic [MUL_W-1:0] MUL_DDY_HYK = 3'd7;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // Sequencer length: compute steps run 0..LAST_STEP, then the hand-off step
  localparam int STEP_W    = 5;
  localparam int LAST_STEP = 19;
  localparam int DONE_STEP = LAST_STEP + 1;

  typedef struct packed {
    logic [1:0] acc_op;
    logic       rnd_long;
  } mac_ctl_t;

  typedef struct packed {
    logic            err_en;
    logic [AX_W-1:0] err_ax;
    logic            derr_en;
    logic [MUL_W-1:0] mul_sel;
    mac_ctl_t        mac;
    logic            rnd_en;
    logic [AX_W-1:0] rnd_dst;
    logic            hyk_en;
  } ucode_t;

  // Operand widths of the shared multiplier
  function automatic int op_a_w(input int dw);
    return (dw + 1 > FIELD_W) ? dw + 1 : FIELD_W;
  endfunction

  function automatic int op_b_w(input int fb);
    return (fb + 14 > 29) ? fb + 14 : 29;
  endfunction

  // Step table: each PD stage is err, kp*err with derr, kd*derr, then add and round
  function automatic ucode_t ucode_at(input logic [STEP_W-1:0] step);
    ucode_t u;
    u = '0;
    case (step)
      STEP_W'(0): begin
        u.err_en = 1'b1; u.err_ax = AX_Z; u.mul_sel = MUL_HYK;
      end
      STEP_W'(1): begin
        u.derr_en = 1'b1; u.mul_sel = MUL_KP_ERR; u.hyk_en = 1'b1;
      end
      STEP_W'(2): begin
        u.err_en = 1'b1; u.err_ax = AX_Y; u.mul_sel = MUL_KD_DERR;
        u.mac.acc_op = ACC_LOAD;
      end
      STEP_W'(3): begin
        u.derr_en = 1'b1; u.mul_sel = MUL_KP_ERR; u.mac.acc_op = ACC_ADD;
      end
      STEP_W'(4): begin
        u.err_en = 1'b1; u.err_ax = AX_X; u.mul_sel = MUL_KD_DERR;
        u.mac.acc_op = ACC_LOAD; u.rnd_en = 1'b1; u.rnd_dst = AX_Z;
      end
      STEP_W'(5): begin
        u.derr_en = 1'b1; u.mul_sel = MUL_KP_ERR; u.mac.acc_op = ACC_ADD;
      end
      STEP_W'(6): begin
        u.err_en = 1'b1; u.err_ax = AX_YAW; u.mul_sel = MUL_KD_DERR;
        u.mac.acc_op = ACC_LOAD; u.rnd_en = 1'b1; u.rnd_dst = AX_Y;
      end
      STEP_W'(7): begin
        u.derr_en = 1'b1; u.mul_sel = MUL_KP_ERR; u.mac.acc_op = ACC_ADD;
      end
      STEP_W'(8): begin
        u.mul_sel = MUL_KD_DERR; u.mac.acc_op = ACC_LOAD;
        u.rnd_en = 1'b1; u.rnd_dst = AX_X;
      end
      STEP_W'(9): begin
        u.mul_sel = MUL_DDX_HYK; u.mac.acc_op = ACC_ADD;
      end
      STEP_W'(10): begin
        u.mul_sel = MUL_DDY_KF; u.mac.acc_op = ACC_LOAD;
        u.rnd_en = 1'b1; u.rnd_dst = AX_YAW;
      end
      STEP_W'(11): begin
        u.mul_sel = MUL_DDX_KF; u.mac.acc_op = ACC_SUB;
      end
      STEP_W'(12): begin
        u.mul_sel = MUL_DDY_HYK; u.mac.acc_op = ACC_LOAD;
        u.rnd_en = 1'b1; u.mac.rnd_long = 1'b1; u.rnd_dst = DST_ROLL_REF;
      end
      STEP_W'(13): begin
        u.err_en = 1'b1; u.err_ax = AX_ROLL; u.mac.acc_op = ACC_ADD;
      end
      STEP_W'(14): begin
        u.derr_en = 1'b1; u.mul_sel = MUL_KP_ERR;
        u.rnd_en = 1'b1; u.mac.rnd_long = 1'b1; u.rnd_dst = DST_PITCH_REF;
      end
      STEP_W'(15): begin
        u.err_en = 1'b1; u.err_ax = AX_PITCH; u.mul_sel = MUL_KD_DERR;
        u.mac.acc_op = ACC_LOAD;
      end
      STEP_W'(16): begin
        u.derr_en = 1'b1; u.mul_sel = MUL_KP_ERR; u.mac.acc_op = ACC_ADD;
      end
      STEP_W'(17): begin
        u.mul_sel = MUL_KD_DERR; u.mac.acc_op = ACC_LOAD;
        u.rnd_en = 1'b1; u.rnd_dst = AX_ROLL;
      end
      STEP_W'(18): begin
        u.mac.acc_op = ACC_ADD;
      end
      STEP_W'(19): begin
        u.rnd_en = 1'b1; u.rnd_dst = AX_PITCH;
      end
      default: begin
        u = '0;
      end
    endcase
    return u;
  endfunction

endpackage

// ===== hdl/cpqc_if.sv =====
// Valid/ready channel interfaces: pose input, command output and register writes
interface cpqc_in_if;
  import cpqc_pkg::*;
  logic   valid;
  logic   ready;
  field_t meas_x;
  field_t meas_y;
  field_t meas_z;
  field_t meas_roll;
  field_t meas_pitch;
  field_t meas_yaw;

  modport source (
    output valid, meas_x, meas_y, meas_z, meas_roll, meas_pitch, meas_yaw,
    input  ready
  );
  modport sink (
    input  valid, meas_x, meas_y, meas_z, meas_roll, meas_pitch, meas_yaw,
    output ready
  );
endinterface

interface cpqc_out_if;
  import cpqc_pkg::*;
  logic   valid;
  logic   ready;
  field_t accel_x_cmd;
  field_t accel_y_cmd;
  field_t thrust_cmd;
  field_t moment_roll;
  field_t moment_pitch;
  field_t moment_yaw;

  modport source (
    output valid, accel_x_cmd, accel_y_cmd, thrust_cmd,
    output moment_roll, moment_pitch, moment_yaw,
    input  ready
  );
  modport sink (
    input  valid, accel_x_cmd, accel_y_cmd, thrust_cmd,
    input  moment_roll, moment_pitch, moment_yaw,
    output ready
  );
endinterface

interface cpqc_cfg_if;
  import cpqc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== hdl/cpqc_mac.sv =====
// Shared multiplier, accumulator and round-and-saturate unit
module cpqc_mac #(
  parameter int DATA_WIDTH = cpqc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cpqc_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  cpqc_pkg::mac_ctl_t                         ctl,
  input  logic signed [cpqc_pkg::op_a_w(DATA_WIDTH)-1:0] op_a,
  input  logic signed [cpqc_pkg::op_b_w(FRAC_BITS)-1:0]  op_b,
  output logic signed [cpqc_pkg::op_a_w(DATA_WIDTH)
                       + cpqc_pkg::op_b_w(FRAC_BITS)-1:0] prod,
  output logic signed [DATA_WIDTH-1:0]               rnd
);
  import cpqc_pkg::*;

  localparam int A_W   = op_a_w(DATA_WIDTH);
  localparam int B_W   = op_b_w(FRAC_BITS);
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = P_W + 1;
  localparam int RW    = ACC_W + 1;

  localparam logic [RW-1:0] HALF_SHORT = RW'(1) << (FRAC_BITS - 1);
  localparam logic [RW-1:0] HALF_LONG  = RW'(1) << (FRAC_BITS + 15);
  localparam logic signed [RW-1:0] SAT_MAX = (RW'(1) <<< (DATA_WIDTH - 1)) - RW'(1);
  localparam logic signed [RW-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [ACC_W-1:0] acc;
  logic signed [RW-1:0]    rnd_sum;
  logic signed [RW-1:0]    rnd_shr;

  // Multiply every cycle; the product is registered before it is summed
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // Accumulate the previous product
  always_ff @(posedge clk) begin
    case (ctl.acc_op)
      ACC_LOAD: acc <= ACC_W'(prod);
      ACC_ADD:  acc <= acc + ACC_W'(prod);
      ACC_SUB:  acc <= acc - ACC_W'(prod);
      default:  acc <= acc;
    endcase
  end

  // Round half up, shift with floor, then saturate to the data width
  always_comb begin
    rnd_sum = RW'(acc) + (ctl.rnd_long ? HALF_LONG : HALF_SHORT);
    rnd_shr = ctl.rnd_long ? (rnd_sum >>> (FRAC_BITS + 16)) : (rnd_sum >>> FRAC_BITS);
    if (rnd_shr > SAT_MAX) begin
      rnd = SAT_MAX[DATA_WIDTH-1:0];
    end else if (rnd_shr < SAT_MIN) begin
      rnd = SAT_MIN[DATA_WIDTH-1:0];
    end else begin
      rnd = rnd_shr[DATA_WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/cascaded_pd_quadrotor_control.sv =====
// Cascaded PD position and attitude controller. One pose beat on in_ch (measured x, y, z,
// roll, pitch, yaw, signed Q8.8) gives one command beat on out_ch (x and y acceleration,
// thrust and three moments, each saturated). All arithmetic runs through a single shared
// multiplier and accumulator stepped by a 21-step sequencer, so in_ch.ready drops for the
// whole item and a new pose is taken only after the item leaves the hand-off step. The
// result sits in an output register, so the next pose is taken while it waits; a new
// result whose predecessor is still untaken holds in the final step until out_ch.ready.
// Register writes on cfg are always ready and are to be made only between items. The
// stored errors and all registers clear on reset.
`include "assert_macros.svh"

module cascaded_pd_quadrotor_control #(
  parameter int DATA_WIDTH = cpqc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cpqc_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  cpqc_in_if.sink          in_ch,
  cpqc_out_if.source       out_ch,
  cpqc_cfg_if.sink         cfg
);
  import cpqc_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int TW     = (DW > FIELD_W) ? DW : FIELD_W;
  localparam int DIFF_W = TW + 1;
  localparam int DD_W   = DW + 1;
  localparam int A_W    = op_a_w(DW);
  localparam int B_W    = op_b_w(FRAC_BITS);
  localparam int P_W    = A_W + B_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  localparam logic signed [B_W-1:0] KG = B_W'(INV_G_Q16);
  localparam logic signed [B_W-1:0] KF = KG <<< FRAC_BITS;
  localparam logic signed [DIFF_W-1:0] ERR_MAX = (DIFF_W'(1) <<< (DW - 1)) - DIFF_W'(1);
  localparam logic signed [DIFF_W-1:0] ERR_MIN = ~ERR_MAX;

  // Sequencer
  logic              st;
  logic [STEP_W-1:0] step;
  ucode_t            uc;
  logic              run;
  logic              accept;
  logic              fin;

  // Registers and stored errors
  gain_t             kp [NUM_AX];
  gain_t             kd [NUM_AX];
  field_t            tx, ty, tz, hy;
  logic signed [DW-1:0] prev_err [NUM_AX];

  // Item working set
  field_t            meas [NUM_AX];
  logic signed [TW-1:0]     tgt_sel;
  field_t                   meas_sel;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DW-1:0]     err_sat;
  logic signed [DW-1:0]     err_r;
  logic [AX_W-1:0]          err_ax_r;
  logic signed [DD_W-1:0]   derr_r;
  logic [AX_W-1:0]          derr_ax_r;
  logic signed [B_W-1:0]    hyk;
  logic signed [DW-1:0]     res [NUM_AX];
  logic signed [DW-1:0]     roll_ref;
  logic signed [DW-1:0]     pitch_ref;

  // Shared unit operands and results
  logic signed [A_W-1:0]    op_a;
  logic signed [B_W-1:0]    op_b;
  logic signed [P_W-1:0]    mac_prod;
  logic signed [DW-1:0]     mac_rnd;

  // Output register
  logic   out_valid;
  field_t out_f [NUM_AX];

  function automatic field_t to_field(input logic signed [DW-1:0] v);
    logic signed [TW-1:0] ext;
    ext = TW'(v);
    return ext[FIELD_W-1:0];
  endfunction

  assign uc     = ucode_at(step);
  assign run    = (st == ST_BUSY);
  assign accept = in_ch.valid && in_ch.ready;
  assign fin    = run && (step == STEP_W'(DONE_STEP)) && (!out_valid || out_ch.ready);

  assign in_ch.ready = (st == ST_IDLE);
  assign cfg.ready   = 1'b1;

  // Select target and measurement of the stage whose error is formed
  always_comb begin
    case (uc.err_ax)
      AX_X:     begin tgt_sel = TW'(tx);        meas_sel = meas[AX_X];     end
      AX_Y:     begin tgt_sel = TW'(ty);        meas_sel = meas[AX_Y];     end
      AX_Z:     begin tgt_sel = TW'(tz);        meas_sel = meas[AX_Z];     end
      AX_ROLL:  begin tgt_sel = TW'(roll_ref);  meas_sel = meas[AX_ROLL];  end
      AX_PITCH: begin tgt_sel = TW'(pitch_ref); meas_sel = meas[AX_PITCH]; end
      AX_YAW:   begin tgt_sel = TW'(hy);        meas_sel = meas[AX_YAW];   end
      default:  begin tgt_sel = '0;             meas_sel = '0;             end
    endcase
    diff = DIFF_W'(tgt_sel) - DIFF_W'(meas_sel);
    if (diff > ERR_MAX) begin
      err_sat = ERR_MAX[DW-1:0];
    end else if (diff < ERR_MIN) begin
      err_sat = ERR_MIN[DW-1:0];
    end else begin
      err_sat = diff[DW-1:0];
    end
  end

  // Steer the shared multiplier
  always_comb begin
    case (uc.mul_sel)
      MUL_HYK:     begin op_a = A_W'(hy);        op_b = KG;                   end
      MUL_KP_ERR:  begin op_a = A_W'(err_r);     op_b = B_W'(kp[err_ax_r]);   end
      MUL_KD_DERR: begin op_a = A_W'(derr_r);    op_b = B_W'(kd[derr_ax_r]);  end
      MUL_DDX_HYK: begin op_a = A_W'(res[AX_X]); op_b = hyk;                  end
      MUL_DDY_KF:  begin op_a = A_W'(res[AX_Y]); op_b = KF;                   end
      MUL_DDX_KF:  begin op_a = A_W'(res[AX_X]); op_b = KF;                   end
      MUL_DDY_HYK: begin op_a = A_W'(res[AX_Y]); op_b = hyk;                  end
      default:     begin op_a = '0;              op_b = '0;                   end
    endcase
  end

  cpqc_mac #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .ctl  (uc.mac),
    .op_a (op_a),
    .op_b (op_b),
    .prod (mac_prod),
    .rnd  (mac_rnd)
  );

  // Control state: sequencer, output valid, registers and stored errors
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      tx        <= '0;
      ty        <= '0;
      tz        <= '0;
      hy        <= '0;
      for (int i = 0; i < NUM_AX; i++) begin
        kp[i]       <= '0;
        kd[i]       <= '0;
        prev_err[i] <= '0;
      end
    end else begin
      // advance the step counter, hold at the hand-off step until the slot frees
      if (accept) begin
        st   <= ST_BUSY;
        step <= '0;
      end else if (run) begin
        if (step != STEP_W'(DONE_STEP)) begin
          step <= step + STEP_W'(1);
        end else if (fin) begin
          st <= ST_IDLE;
        end
      end

      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      // keep this item's error for the next one
      if (run && uc.derr_en) begin
        prev_err[err_ax_r] <= err_r;
      end

      // register write beat; indexes beyond the list drop
      if (cfg.valid) begin
        case (cfg.index)
          REG_GAINS_X, REG_GAINS_Y, REG_GAINS_Z,
          REG_GAINS_ROLL, REG_GAINS_PITCH, REG_GAINS_YAW: begin
            kp[cfg.index[AX_W-1:0]] <= cfg.wdata[GAIN_W-1:0];
            kd[cfg.index[AX_W-1:0]] <= cfg.wdata[2*GAIN_W-1:GAIN_W];
          end
          REG_POS_TARGET: begin
            tx <= cfg.wdata[FIELD_W-1:0];
            ty <= cfg.wdata[2*FIELD_W-1:FIELD_W];
            tz <= cfg.wdata[3*FIELD_W-1:2*FIELD_W];
          end
          REG_HEADING: begin
            hy <= cfg.wdata[FIELD_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      meas[AX_X]     <= in_ch.meas_x;
      meas[AX_Y]     <= in_ch.meas_y;
      meas[AX_Z]     <= in_ch.meas_z;
      meas[AX_ROLL]  <= in_ch.meas_roll;
      meas[AX_PITCH] <= in_ch.meas_pitch;
      meas[AX_YAW]   <= in_ch.meas_yaw;
    end
    if (run && uc.err_en) begin
      err_r    <= err_sat;
      err_ax_r <= uc.err_ax;
    end
    if (run && uc.derr_en) begin
      derr_r    <= DD_W'(err_r) - DD_W'(prev_err[err_ax_r]);
      derr_ax_r <= err_ax_r;
    end
    if (run && uc.hyk_en) begin
      hyk <= mac_prod[B_W-1:0];
    end
    // drop the rounded value into its slot
    if (run && uc.rnd_en) begin
      case (uc.rnd_dst)
        DST_ROLL_REF:  roll_ref  <= mac_rnd;
        DST_PITCH_REF: pitch_ref <= mac_rnd;
        default:       res[uc.rnd_dst] <= mac_rnd;
      endcase
    end
    if (fin) begin
      for (int i = 0; i < NUM_AX; i++) begin
        out_f[i] <= to_field(res[i]);
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.accel_x_cmd  = out_f[AX_X];
  assign out_ch.accel_y_cmd  = out_f[AX_Y];
  assign out_ch.thrust_cmd   = out_f[AX_Z];
  assign out_ch.moment_roll  = out_f[AX_ROLL];
  assign out_ch.moment_pitch = out_f[AX_PITCH];
  assign out_ch.moment_yaw   = out_f[AX_YAW];

  `ASSERT_STD(a_accept_starts_seq, accept |=> (run && step == '0), "accept did not start a run")
  `ASSERT_STD(a_step_in_range, run |-> (step <= STEP_W'(DONE_STEP)), "step past hand-off")
  `ASSERT_STD(a_result_from_done, $rose(out_valid) |-> $past(fin), "result outside hand-off")
  `ASSERT_STD(a_idle_after_done, $fell(run) |-> $past(step == STEP_W'(DONE_STEP)), "early idle")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the cascaded PD position and attitude controller
`timescale 1ns / 100ps

module tb_top;
  import cpqc_pkg::*;

  localparam int HALF_PERIOD      = 6;
  localparam int RESET_CYCLES     = 5;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int TAIL_CYCLES      = 30;
  localparam int MAX_REPORTS      = 10;
  localparam int NUM_PHASES       = 4;
  localparam int BLOCKS_PER_PHASE = 3;
  localparam int ITEMS_PER_BLOCK  = 150;

  // One pose or one command beat, one 16-bit slot per axis code
  typedef logic [NUM_AX-1:0][FIELD_W-1:0] axes_t;

  logic clk = 1'b0;
  logic rst;

  cpqc_in_if  pose_ch ();
  cpqc_out_if cmd_ch ();
  cpqc_cfg_if cfg_ch ();

  cascaded_pd_quadrotor_control i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (pose_ch),
    .out_ch (cmd_ch),
    .cfg    (cfg_ch)
  );

  // Shadow copy of the controller registers and stored errors
  logic [31:0] gain_reg [NUM_AX];
  logic [47:0] pos_target_reg;
  field_t      heading_reg;
  longint      prev_err [NUM_AX];

  axes_t cmd_q [$];
  axes_t got_cmd;
  axes_t want_cmd;
  int    fail_count;
  int    report_count;
  int    idle_pct;
  int    stall_pct;
  int    quiet_cycles;

  // Clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic longint sx16(logic [15:0] v);
    field_t s;
    s = v;
    return s;
  endfunction

  function automatic longint sat_data(longint v);
    longint hi;
    hi = (longint'(1) <<< (DATA_WIDTH_DEF - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Round half up, then floor shift
  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // One PD stage; updates the stored error of the axis
  function automatic longint pd_axis(logic [AX_W-1:0] ax, longint tgt, longint meas);
    gain_t  kp;
    gain_t  kd;
    longint err;
    longint derr;
    kp = gain_reg[ax][15:0];
    kd = gain_reg[ax][31:16];
    err = sat_data(tgt - meas);
    derr = err - prev_err[ax];
    prev_err[ax] = err;
    return sat_data(round_q(kp * err + kd * derr, FRAC_BITS_DEF));
  endfunction

  // Full cascade: position stages, desired angles, attitude stages
  function automatic axes_t pd_cascade_cmd(axes_t m);
    longint ddx;
    longint ddy;
    longint ddz;
    longint hy;
    longint one;
    longint roll_ref;
    longint pitch_ref;
    axes_t  c;
    hy  = heading_reg;
    one = longint'(1) <<< FRAC_BITS_DEF;
    ddz = pd_axis(AX_Z, sx16(pos_target_reg[47:32]), sx16(m[AX_Z]));
    ddy = pd_axis(AX_Y, sx16(pos_target_reg[31:16]), sx16(m[AX_Y]));
    ddx = pd_axis(AX_X, sx16(pos_target_reg[15:0]), sx16(m[AX_X]));
    roll_ref  = sat_data(round_q((ddx * hy - ddy * one) * INV_G_Q16, FRAC_BITS_DEF + 16));
    pitch_ref = sat_data(round_q((ddx * one + ddy * hy) * INV_G_Q16, FRAC_BITS_DEF + 16));
    c[AX_X]     = 16'(ddx);
    c[AX_Y]     = 16'(ddy);
    c[AX_Z]     = 16'(ddz);
    c[AX_ROLL]  = 16'(pd_axis(AX_ROLL, roll_ref, sx16(m[AX_ROLL])));
    c[AX_PITCH] = 16'(pd_axis(AX_PITCH, pitch_ref, sx16(m[AX_PITCH])));
    c[AX_YAW]   = 16'(pd_axis(AX_YAW, hy, sx16(m[AX_YAW])));
    return c;
  endfunction

  // Q8.8 value: extremes, small magnitudes or anything
  function automatic logic [15:0] rand_fixed();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4, 5, 6: return 16'($urandom_range(1024)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // Measurement: close to its target half the time, else extremes or noise
  function automatic logic [15:0] rand_meas(logic [15:0] tgt);
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      default: return tgt + 16'($urandom_range(511)) - 16'd256;
    endcase
  endfunction

  function automatic axes_t rand_pose();
    axes_t m;
    m[AX_X]     = rand_meas(pos_target_reg[15:0]);
    m[AX_Y]     = rand_meas(pos_target_reg[31:16]);
    m[AX_Z]     = rand_meas(pos_target_reg[47:32]);
    m[AX_ROLL]  = rand_meas(16'h0000);
    m[AX_PITCH] = rand_meas(16'h0000);
    m[AX_YAW]   = rand_meas(heading_reg);
    return m;
  endfunction

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_GAINS_X, REG_GAINS_Y, REG_GAINS_Z,
      REG_GAINS_ROLL, REG_GAINS_PITCH, REG_GAINS_YAW: begin
        gain_reg[idx[AX_W-1:0]] = value[31:0];
      end
      REG_POS_TARGET: begin
        pos_target_reg = value[47:0];
      end
      REG_HEADING: begin
        heading_reg = value[15:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic write_all_gains(logic [31:0] gains);
    for (int a = 0; a < NUM_AX; a++) write_reg(REG_GAINS_X + CFG_IDX_W'(a), 48'(gains));
  endtask

  // Send one pose beat after a random gap and queue its command
  task automatic send_pose(axes_t m);
    while ($urandom_range(99) < idle_pct) begin
      pose_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pose_ch.valid      <= 1'b1;
    pose_ch.meas_x     <= m[AX_X];
    pose_ch.meas_y     <= m[AX_Y];
    pose_ch.meas_z     <= m[AX_Z];
    pose_ch.meas_roll  <= m[AX_ROLL];
    pose_ch.meas_pitch <= m[AX_PITCH];
    pose_ch.meas_yaw   <= m[AX_YAW];
    do @(posedge clk); while (!pose_ch.ready);
    cmd_q.push_back(pd_cascade_cmd(m));
  endtask

  // Hold the sender until every queued command has come back
  task automatic drain_results();
    pose_ch.valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_config();
    for (int a = 0; a < NUM_AX; a++) begin
      write_reg(REG_GAINS_X + CFG_IDX_W'(a), {16'($urandom), rand_fixed(), rand_fixed()});
    end
    write_reg(REG_POS_TARGET, {rand_fixed(), rand_fixed(), rand_fixed()});
    write_reg(REG_HEADING, {32'($urandom), rand_fixed()});
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_HEADING) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'({$urandom, $urandom}));
  endtask

  // First beat after reset: stored errors start at zero
  task automatic test_first_item();
    write_all_gains({16'h0200, 16'h0100});
    write_reg(REG_POS_TARGET, {16'h0200, 16'hFF00, 16'h0100});
    write_reg(REG_HEADING, 48'h0080);
    send_pose({16'h0000, 16'hFFF0, 16'h0010, 16'hFE00, 16'h0000, 16'h0080});
    send_pose({16'h0000, 16'hFFF0, 16'h0010, 16'hFE00, 16'h0000, 16'h0080});
  endtask

  // Error and output saturation at the field and gain extremes
  task automatic test_saturation();
    drain_results();
    for (int a = 0; a < NUM_AX; a++) begin
      write_reg(REG_GAINS_X + CFG_IDX_W'(a), (a < 3) ? 48'h7FFF7FFF : 48'h80008000);
    end
    write_reg(REG_POS_TARGET, 48'h7FFF7FFF7FFF);
    write_reg(REG_HEADING, 48'h7FFF);
    send_pose({NUM_AX{16'h8000}});
    send_pose({NUM_AX{16'h7FFF}});
    send_pose({NUM_AX{16'h8000}});
    send_pose({NUM_AX{16'h0000}});
    drain_results();
    write_all_gains({16'h7FFF, 16'h8000});
    write_reg(REG_POS_TARGET, 48'h800080008000);
    write_reg(REG_HEADING, 48'h8000);
    send_pose({NUM_AX{16'h7FFF}});
    send_pose({NUM_AX{16'h8000}});
    send_pose({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    send_pose({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
  endtask

  // Unknown indices are ignored and bits above a register's width dropped
  task automatic test_register_writes();
    drain_results();
    write_all_gains({16'h0180, 16'hFF40});
    write_reg(REG_POS_TARGET, 48'h0100_FF80_0040);
    write_reg(REG_HEADING, 48'hFFFF_FFFF_0100);
    for (int i = int'(REG_HEADING) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), '1);
    end
    for (int a = 0; a < NUM_AX; a++) write_reg(REG_GAINS_X + CFG_IDX_W'(a), 48'hA5A5_0100_0080);
    send_pose({16'h0040, 16'hFFC0, 16'h0020, 16'h0000, 16'h0100, 16'hFF00});
    send_pose({16'hFFC0, 16'h0040, 16'hFFE0, 16'h0200, 16'hFF00, 16'h0100});
    send_pose({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    drain_results();
    write_all_gains(32'h0000_0000);
    send_pose({16'h1234, 16'hEDCB, 16'h7FFF, 16'h8000, 16'h0F0F, 16'hF0F0});
    send_pose({16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA});
  endtask

  // Random poses under each idling mix, with fresh settings per block
  task automatic test_random_traffic();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
        drain_results();
        random_config();
        for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
          if (n == ITEMS_PER_BLOCK / 2) drain_results();
          send_pose(rand_pose());
        end
      end
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    cmd_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each command beat with the oldest queued prediction
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      got_cmd[AX_X]     = cmd_ch.accel_x_cmd;
      got_cmd[AX_Y]     = cmd_ch.accel_y_cmd;
      got_cmd[AX_Z]     = cmd_ch.thrust_cmd;
      got_cmd[AX_ROLL]  = cmd_ch.moment_roll;
      got_cmd[AX_PITCH] = cmd_ch.moment_pitch;
      got_cmd[AX_YAW]   = cmd_ch.moment_yaw;
      if (cmd_q.size() == 0) begin
        fail_count++;
        if (report_count < MAX_REPORTS) begin
          $display("%0t: command beat with none expected: %h", $realtime, got_cmd);
        end
        report_count++;
      end else begin
        want_cmd = cmd_q.pop_front();
        for (int i = 0; i < NUM_AX; i++) begin
          if (got_cmd[i] !== want_cmd[i]) begin
            fail_count++;
            if (report_count < MAX_REPORTS) begin
              $display("%0t: slot %0d expected %h got %h", $realtime, i,
                       want_cmd[i], got_cmd[i]);
            end
            report_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (pose_ch.valid && pose_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                = 1'b1;
    pose_ch.valid      = 1'b0;
    pose_ch.meas_x     = '0;
    pose_ch.meas_y     = '0;
    pose_ch.meas_z     = '0;
    pose_ch.meas_roll  = '0;
    pose_ch.meas_pitch = '0;
    pose_ch.meas_yaw   = '0;
    cmd_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.wdata       = '0;
    idle_pct           = 0;
    stall_pct          = 0;
    fail_count         = 0;
    report_count       = 0;
    quiet_cycles       = 0;
    pos_target_reg     = '0;
    heading_reg        = '0;
    for (int a = 0; a < NUM_AX; a++) begin
      gain_reg[a] = '0;
      prev_err[a] = 0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_item();
    test_saturation();
    test_register_writes();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cpqc_pkg.sv
hdl/cpqc_if.sv
hdl/cpqc_mac.sv
hdl/cascaded_pd_quadrotor_control.sv
sim/tb_top.sv
